>>> src/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants for the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Fixed control characters.
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

  // Configuration register reset values: comma and double quote.
  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'h2C;
  localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'h22;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE     = 2'd1;

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIELD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROW   = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_in;
    logic              end_of_text;
  } csvt_in_t;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [BYTE_W-1:0] out_byte;
  } csvt_out_t;

  // Parser flags carried from one byte to the next.
  typedef struct packed {
    logic inside_quotes;
    logic quote_pending;
    logic swallow_lf;
    logic field_has_data;
    logic row_has_fields;
  } csvt_state_t;

endpackage

>>> src/csvt_step.sv
// ----------------------------------------------------------------------------
// csvt_step
// Combinational decode of one byte: next parser flags and optional token.
// ----------------------------------------------------------------------------
module csvt_step
  import csvt_pkg::*;
(
  input  csvt_in_t          item,
  input  csvt_state_t       st,
  input  logic [BYTE_W-1:0] delimiter_char,
  input  logic [BYTE_W-1:0] quote_char,
  output csvt_state_t       st_nxt,
  output logic              emit,
  output csvt_out_t         token
);

  logic [BYTE_W-1:0] b;
  logic              is_quote;
  logic              is_delim;

  assign b        = item.byte_in;
  assign is_quote = (b == quote_char);
  assign is_delim = (b == delimiter_char);

  always_comb begin
    logic go;
    logic outside;
    st_nxt           = st;
    emit             = 1'b0;
    token.token_kind = KIND_DATA;
    token.out_byte   = '0;
    go               = 1'b1;
    outside          = 1'b0;

    if (item.end_of_text) begin
      // Flush the last row, then return every flag to its reset value.
      if (st.field_has_data || st.row_has_fields) begin
        emit             = 1'b1;
        token.token_kind = KIND_ROW;
      end
      st_nxt = '0;
    end else begin
      st_nxt.swallow_lf = 1'b0;
      if (st.swallow_lf && (b == CH_LF)) begin
        go = 1'b0;
      end

      if (go) begin
        if (st.quote_pending) begin
          st_nxt.quote_pending = 1'b0;
          if (is_quote) begin
            // Doubled quote gives one literal quote byte.
            st_nxt.field_has_data = 1'b1;
            emit                  = 1'b1;
            token.out_byte        = b;
          end else begin
            st_nxt.inside_quotes = 1'b0;
            outside              = 1'b1;
          end
        end else if (st.inside_quotes) begin
          if (is_quote) begin
            st_nxt.quote_pending = 1'b1;
          end else begin
            st_nxt.field_has_data = 1'b1;
            emit                  = 1'b1;
            token.out_byte        = b;
          end
        end else begin
          outside = 1'b1;
        end

        if (outside) begin
          if (is_quote) begin
            st_nxt.inside_quotes = 1'b1;
          end else if (is_delim) begin
            st_nxt.field_has_data = 1'b0;
            st_nxt.row_has_fields = 1'b1;
            emit                  = 1'b1;
            token.token_kind      = KIND_FIELD;
          end else if ((b == CH_LF) || (b == CH_CR)) begin
            if (st.field_has_data || st.row_has_fields) begin
              st_nxt.field_has_data = 1'b0;
              st_nxt.row_has_fields = 1'b0;
              emit                  = 1'b1;
              token.token_kind      = KIND_ROW;
            end
            if (b == CH_CR) begin
              st_nxt.swallow_lf = 1'b1;
            end
          end else begin
            st_nxt.field_has_data = 1'b1;
            emit                  = 1'b1;
            token.out_byte        = b;
          end
        end
      end
    end
  end

endmodule

>>> src/csv_field_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Byte-serial CSV tokenizer emitting data bytes, field ends and row ends.
// ----------------------------------------------------------------------------
// Each byte passes from the input register to the result register.
// Throughput: one byte per cycle unless out_ready stalls the output; one decode
// stage between the two registers, parser flags updated as each byte leaves it.
// Reset (rst_n low, synchronous): pipeline emptied, parser flags cleared,
// delimiter set to comma and quote to double quote.
module csv_field_tokenizer
  import csvt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  csvt_in_t             in_data,

  output logic                 out_valid,
  input  logic                 out_ready,
  output csvt_out_t            out_data,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  // Configuration registers. Writes are always taken; the user must send them only
  // while the tokenizer is idle. The block does not enforce this; it has no interlock.
  logic [BYTE_W-1:0] delim_r;
  logic [BYTE_W-1:0] quote_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
      quote_r <= QUOTE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DELIMITER: delim_r <= cfg_data;
        CFG_QUOTE:     quote_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Result register. Bytes that produce no token pass through without
  // occupying it.
  logic      out_valid_r;
  csvt_out_t out_data_r;

  // Input register. The held byte moves on whenever the result register is
  // empty or is being drained in this cycle, so a new transaction can be
  // accepted every cycle while results keep flowing.
  logic        s1_valid_r;
  csvt_in_t    s1_item_r;
  logic        advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // Parser flags and the per-byte decode.
  csvt_state_t st_r;
  csvt_state_t st_nxt;
  logic        step_emit;
  csvt_out_t   step_token;

  csvt_step u_step (
    .item           (s1_item_r),
    .st             (st_r),
    .delimiter_char (delim_r),
    .quote_char     (quote_r),
    .st_nxt         (st_nxt),
    .emit           (step_emit),
    .token          (step_token)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step_emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_emit) begin
      out_data_r <= step_token;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A pending quote only exists within a quoted section.
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r.quote_pending |-> st_r.inside_quotes)
    else $error("quote pending outside a quoted section");

  // The LF swallow flag is only set by a CR seen outside quotes.
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r.swallow_lf |-> (!st_r.inside_quotes && !st_r.quote_pending))
    else $error("swallow flag set inside quotes");

  // A row end leaves an empty field and an empty row behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step_emit && (step_token.token_kind == KIND_ROW))
      |=> (!st_r.field_has_data && !st_r.row_has_fields))
    else $error("row end did not clear field and row flags");

  // Only defined token kinds reach the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.token_kind == KIND_DATA ||
                     out_data_r.token_kind == KIND_FIELD ||
                     out_data_r.token_kind == KIND_ROW))
    else $error("undefined token kind at output");

endmodule
